/* rtl/core/ilsa_pkg.sv */
// ----------------------------------------------------------------------------
// ilsa_pkg
// Shared constants and types for the lane starvation arbiter.
// ----------------------------------------------------------------------------
package ilsa_pkg;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned BATCH_W     = 16;

  typedef logic [1:0]             lane_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [BATCH_W-1:0]     batch_t;

  localparam lane_t LANE_EMERGENCY = 2'd0;
  localparam lane_t LANE_READ      = 2'd1;
  localparam lane_t LANE_WRITE     = 2'd2;
  localparam lane_t LANE_NONE      = 2'd3;

  localparam cfg_index_t REG_STARVE_READ  = 2'd0;
  localparam cfg_index_t REG_STARVE_WRITE = 2'd1;
  localparam cfg_index_t REG_BATCH_READ   = 2'd2;
  localparam cfg_index_t REG_BATCH_WRITE  = 2'd3;

  localparam cnt_t   RST_STARVE_READ  = 32'd5;
  localparam cnt_t   RST_STARVE_WRITE = 32'd20;
  localparam batch_t RST_BATCH_LEN    = 16'd16;
  localparam cnt_t   CNT_MAX          = '1;

endpackage

/* rtl/core/io_lane_starvation_arbiter.sv */
// ----------------------------------------------------------------------------
// io_lane_starvation_arbiter
// An accepted item's result enters the output register in the next cycle.
// Throughput: 1 item per cycle unless out_stall holds the output; the grant
// decision and counter update logic sits between lane state and result regs.
// Reset (rst_n, synchronous): counters and batches zero, limits 5 / 20,
// batch lengths 16, output register empty.
// ----------------------------------------------------------------------------
module io_lane_starvation_arbiter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  ilsa_pkg::cfg_index_t cfg_index,
  input  ilsa_pkg::cfg_data_t  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_emergency_ready,
  input  logic                 in_read_ready,
  input  logic                 in_write_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ilsa_pkg::lane_t      out_grant_lane,
  output logic                 out_starvation_served
);
  import ilsa_pkg::*;

  cnt_t   lim_rd_r, lim_wr_r;
  batch_t len_rd_r, len_wr_r;
  cnt_t   byp_rd_r, byp_wr_r, byp_rd_nxt, byp_wr_nxt;
  batch_t bat_rd_r, bat_wr_r, bat_rd_nxt, bat_wr_nxt;
  logic   out_valid_r;
  lane_t  grant_r, grant_nxt;
  logic   served_r, served_nxt;
  logic   accept;
  logic   starve_rd, starve_wr;

  assign in_stall              = out_valid_r & out_stall;
  assign accept                = in_valid & ~in_stall;
  assign out_valid             = out_valid_r;
  assign out_grant_lane        = grant_r;
  assign out_starvation_served = served_r;

  assign starve_rd = in_read_ready  & (byp_rd_r >= lim_rd_r);
  assign starve_wr = in_write_ready & (byp_wr_r >= lim_wr_r);

  always_comb begin
    byp_rd_nxt = byp_rd_r;
    byp_wr_nxt = byp_wr_r;
    bat_rd_nxt = bat_rd_r;
    bat_wr_nxt = bat_wr_r;
    grant_nxt  = LANE_NONE;
    served_nxt = 1'b0;
    if (in_emergency_ready) begin
      grant_nxt = LANE_EMERGENCY;
    end else if (starve_wr || starve_rd) begin
      grant_nxt  = starve_wr ? LANE_WRITE : LANE_READ;
      served_nxt = 1'b1;
      byp_rd_nxt = '0;
      byp_wr_nxt = '0;
      bat_rd_nxt = '0;
      bat_wr_nxt = '0;
    end else if (in_read_ready) begin
      grant_nxt = LANE_READ;
      if (bat_rd_r != '0) begin
        bat_rd_nxt = bat_rd_r - 1'b1;
      end else begin
        bat_rd_nxt = len_rd_r - 1'b1;
        bat_wr_nxt = '0;
      end
      if (byp_wr_r != CNT_MAX) byp_wr_nxt = byp_wr_r + 1'b1;
    end else if (in_write_ready) begin
      grant_nxt = LANE_WRITE;
      if (bat_wr_r != '0) begin
        bat_wr_nxt = bat_wr_r - 1'b1;
      end else begin
        bat_wr_nxt = len_wr_r - 1'b1;
        bat_rd_nxt = '0;
      end
      if (byp_rd_r != CNT_MAX) byp_rd_nxt = byp_rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_rd_r    <= RST_STARVE_READ;
      lim_wr_r    <= RST_STARVE_WRITE;
      len_rd_r    <= RST_BATCH_LEN;
      len_wr_r    <= RST_BATCH_LEN;
      byp_rd_r    <= '0;
      byp_wr_r    <= '0;
      bat_rd_r    <= '0;
      bat_wr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STARVE_READ:  lim_rd_r <= cfg_data;
          REG_STARVE_WRITE: lim_wr_r <= cfg_data;
          REG_BATCH_READ:   len_rd_r <= cfg_data[BATCH_W-1:0];
          REG_BATCH_WRITE:  len_wr_r <= cfg_data[BATCH_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        byp_rd_r <= byp_rd_nxt;
        byp_wr_r <= byp_wr_nxt;
        bat_rd_r <= bat_rd_nxt;
        bat_wr_r <= bat_wr_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grant_r  <= grant_nxt;
      served_r <= served_nxt;
    end
  end

endmodule
